>>> src/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg: shared definitions for the horizontal Sobel gradient block
// Constants, the stage handoff record and small helper functions used by the
// control, window and line memory modules.
// ----------------------------------------------------------------------------
package sve_pkg;

    // Frame limits and field widths.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DIM_W      = 10;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int LINE_W     = 2 * PIX_W;
    localparam int SUM_W      = PIX_W + 2;

    localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_DIM    = DIM_W'(512);
    localparam logic [PIX_W-1:0] PIX_MAX      = PIX_W'(255);

    // Request codes.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Everything the window stage needs to know about one item.
    typedef struct packed {
        logic              emit;
        logic              row_end;
        logic              frame_end;
        logic              use_left;
        logic              use_right;
        logic              skip_top;
        logic              skip_bot;
        logic              we;
        logic              oob;
        logic              fwd;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } sve_item_t;

    // A zero dimension acts as one, an oversized one as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Weighted column sum 1,2,1 with rows outside the image dropped.
    function automatic logic [SUM_W-1:0] col_sum(input logic [PIX_W-1:0] t,
                                                 input logic [PIX_W-1:0] m,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic skip_t,
                                                 input logic skip_b);
        logic [SUM_W-1:0] s;
        s = {1'b0, m, 1'b0};
        if (!skip_t)
        begin
            s = s + SUM_W'(t);
        end
        if (!skip_b)
        begin
            s = s + SUM_W'(b);
        end
        return s;
    endfunction

endpackage

>>> src/sve_line_mem.sv
// ----------------------------------------------------------------------------
// sve_line_mem: line buffer storage
// One synchronous memory holds both buffered rows per column, upper byte the
// row above, lower byte the middle row. A sweep after reset zeroes it.
// ----------------------------------------------------------------------------
module sve_line_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [sve_pkg::ADDR_W-1:0] rd_addr,
    output logic [sve_pkg::LINE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [sve_pkg::ADDR_W-1:0] wr_addr,
    input  logic [sve_pkg::LINE_W-1:0] wr_data,
    output logic                       busy
);
    import sve_pkg::*;

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [LINE_W-1:0] mem_data;

    // Clearing sweep, one entry per cycle.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Write port shared by the sweep and the pipeline.
    always_comb
    begin
        mem_we   = busy_reg | wr_en;
        mem_addr = busy_reg ? clr_addr_reg : wr_addr;
        mem_data = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

>>> src/sve_ctrl.sv
// ----------------------------------------------------------------------------
// sve_ctrl: raster counters and item decode
// Tracks input and output positions, decides which items enter the pipeline,
// issues the line memory read and flags same-column overlap for forwarding.
// ----------------------------------------------------------------------------
module sve_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       advance,
    input  logic                       req_type,
    input  logic [sve_pkg::PIX_W-1:0]  pixel_value,
    input  logic [sve_pkg::DIM_W-1:0]  image_width,
    input  logic [sve_pkg::DIM_W-1:0]  image_height,
    output logic                       rd_en,
    output logic [sve_pkg::ADDR_W-1:0] rd_addr,
    output logic                       s1_valid,
    output sve_pkg::sve_item_t         s1_item
);
    import sve_pkg::*;

    logic [DIM_W-1:0] in_col_reg,  in_col_next;
    logic [DIM_W-1:0] in_row_reg,  in_row_next;
    logic [DIM_W-1:0] out_col_reg, out_col_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next;
    logic             s1_valid_reg, s1_valid_next;
    sve_item_t        s1_item_reg,  s1_item_next;

    logic [DIM_W-1:0] w, h, c, r, oc, orow;
    logic [DIM_W:0]   c_inc, oc_inc, orow_inc;
    logic             is_drain, start_new, ignore, take, oob, emit, row_end;

    // Decode the item against the current positions.
    always_comb
    begin
        w         = eff_dim(image_width, MAX_WIDTH_D);
        h         = eff_dim(image_height, MAX_HEIGHT_D);
        is_drain  = (req_type == REQ_DRAIN);
        start_new = !is_drain && (in_row_reg >= h);
        ignore    = is_drain && ((in_row_reg < h) || (out_row_reg >= h));
        take      = accept && !ignore;
        c         = start_new ? '0 : in_col_reg;
        r         = start_new ? '0 : in_row_reg;
        oc        = start_new ? '0 : out_col_reg;
        orow      = start_new ? '0 : out_row_reg;
        c_inc     = {1'b0, c} + (DIM_W+1)'(1);
        oc_inc    = {1'b0, oc} + (DIM_W+1)'(1);
        orow_inc  = {1'b0, orow} + (DIM_W+1)'(1);
        oob       = (c >= DIM_W'(MAX_WIDTH));
        emit      = ((r >= DIM_W'(2)) || ((r == DIM_W'(1)) && (c != '0))) && (orow < h);
        row_end   = (oc_inc >= {1'b0, w});
    end

    // Next positions.
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take)
        begin
            if (c_inc >= {1'b0, w})
            begin
                in_col_next = '0;
                in_row_next = r + DIM_W'(1);
            end
            else
            begin
                in_col_next = c_inc[DIM_W-1:0];
                in_row_next = r;
            end
            out_col_next = oc;
            out_row_next = orow;
            if (emit)
            begin
                if (row_end)
                begin
                    out_col_next = '0;
                    out_row_next = orow_inc[DIM_W-1:0];
                end
                else
                begin
                    out_col_next = oc_inc[DIM_W-1:0];
                end
            end
        end
    end

    // Stage record for the window stage.
    always_comb
    begin
        s1_valid_next          = s1_valid_reg;
        s1_item_next           = s1_item_reg;
        if (advance)
        begin
            s1_valid_next          = take;
            s1_item_next.emit      = emit;
            s1_item_next.row_end   = row_end;
            s1_item_next.frame_end = row_end && (orow_inc >= {1'b0, h});
            s1_item_next.use_left  = (oc != '0);
            s1_item_next.use_right = (c != '0) && !row_end;
            s1_item_next.skip_top  = (orow == '0);
            s1_item_next.skip_bot  = (orow_inc >= {1'b0, h});
            s1_item_next.we        = !oob;
            s1_item_next.oob       = oob;
            s1_item_next.addr      = c[ADDR_W-1:0];
            s1_item_next.pix       = is_drain ? '0 : pixel_value;
            // The item ahead writes this column at the same edge as the read.
            s1_item_next.fwd       = s1_valid_reg && s1_item_reg.we &&
                                     (s1_item_reg.addr == c[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    assign rd_en    = take && !oob;
    assign rd_addr  = c[ADDR_W-1:0];
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

>>> src/sve_window.sv
// ----------------------------------------------------------------------------
// sve_window: window, gradient and result register
// Takes the buffered column from memory or the forward path, writes the line
// buffers back, shifts the window and registers the clamped gradient.
// ----------------------------------------------------------------------------
module sve_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       s1_valid,
    input  sve_pkg::sve_item_t         s1_item,
    input  logic [sve_pkg::LINE_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [sve_pkg::ADDR_W-1:0] wr_addr,
    output logic [sve_pkg::LINE_W-1:0] wr_data,
    output logic                       res_valid,
    output logic [sve_pkg::PIX_W-1:0]  edge_value,
    output logic                       row_end,
    output logic                       frame_end
);
    import sve_pkg::*;

    logic [PIX_W-1:0]  c1_top_reg, c1_mid_reg, c1_bot_reg;
    logic [PIX_W-1:0]  c2_top_reg, c2_mid_reg, c2_bot_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              res_valid_reg, res_valid_next;
    logic [PIX_W-1:0]  edge_reg, edge_next;
    logic              row_end_reg, frame_end_reg;
    logic [LINE_W-1:0] line;
    logic [PIX_W-1:0]  top, mid;
    logic [SUM_W-1:0]  right_sum, left_sum;
    logic signed [SUM_W:0] acc;

    // Column read for this item, with the forward path and blank columns.
    always_comb
    begin
        line = s1_item.fwd ? fwd_data_reg : rd_data;
        top  = s1_item.oob ? '0 : line[LINE_W-1:PIX_W];
        mid  = s1_item.oob ? '0 : line[PIX_W-1:0];
    end

    // Line buffer write back: the middle row moves up, the new pixel enters.
    assign wr_en   = s1_valid && advance && s1_item.we;
    assign wr_addr = s1_item.addr;
    assign wr_data = {mid, s1_item.pix};

    // Gradient: new right column minus the column that shifts to the left.
    always_comb
    begin
        right_sum = s1_item.use_right ?
                    col_sum(top, mid, s1_item.pix, s1_item.skip_top, s1_item.skip_bot) : '0;
        left_sum  = s1_item.use_left ?
                    col_sum(c1_top_reg, c1_mid_reg, c1_bot_reg,
                            s1_item.skip_top, s1_item.skip_bot) : '0;
        acc       = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        if (acc < 0)
        begin
            edge_next = '0;
        end
        else if (acc > $signed((SUM_W+1)'(PIX_MAX)))
        begin
            edge_next = PIX_MAX;
        end
        else
        begin
            edge_next = acc[PIX_W-1:0];
        end
        res_valid_next = advance ? (s1_valid && s1_item.emit) : res_valid_reg;
    end

    // Window columns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_top_reg    <= '0;
            c1_mid_reg    <= '0;
            c1_bot_reg    <= '0;
            c2_top_reg    <= '0;
            c2_mid_reg    <= '0;
            c2_bot_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (s1_valid && advance)
            begin
                c1_top_reg <= c2_top_reg;
                c1_mid_reg <= c2_mid_reg;
                c1_bot_reg <= c2_bot_reg;
                c2_top_reg <= top;
                c2_mid_reg <= mid;
                c2_bot_reg <= s1_item.pix;
            end
        end
    end

    // Result payload and forward copy of the entry just written.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_data_reg  <= wr_data;
            edge_reg      <= edge_next;
            row_end_reg   <= s1_item.row_end;
            frame_end_reg <= s1_item.frame_end;
        end
    end

    assign res_valid  = res_valid_reg;
    assign edge_value = edge_reg;
    assign row_end    = row_end_reg;
    assign frame_end  = frame_end_reg;

endmodule

>>> src/sobel_vertical_edge_3x3.sv
// ----------------------------------------------------------------------------
// sobel_vertical_edge_3x3: streaming 3x3 horizontal Sobel gradient
// Raster pixels in, clamped gradients out, one row plus one pixel behind.
//
//   channel   signals                                  direction
//   pixel     pix_valid, pix_stall, req_type, pixel_value  in
//   result    res_valid, res_stall, edge_value, row_end, frame_end  out
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB
//
// One item per clock while pix_stall is low: the line memory is read at the
// item's column on transfer and written back by the window stage through
// its single write port. A result enters the output register as its item
// leaves the stage record. After reset a sweep zeroes all 512 line memory
// entries; pix_stall is high meanwhile, register writes are taken as ever.
// A held result with res_stall high stalls the whole pipeline.
// ----------------------------------------------------------------------------
module sobel_vertical_edge_3x3 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_stall,
    input  logic                      req_type,
    input  logic [sve_pkg::PIX_W-1:0] pixel_value,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [sve_pkg::PIX_W-1:0] edge_value,
    output logic                      row_end,
    output logic                      frame_end,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import sve_pkg::*;

    logic [DIM_W-1:0]  width_reg,  width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic              cfg_wr;
    logic              reg_sel;
    logic              advance, accept, mem_busy;
    logic              rd_en, wr_en, s1_valid;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [LINE_W-1:0] rd_data, wr_data;
    sve_item_t         s1_item;

    // Configuration registers.
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_DIM;
            height_reg <= RESET_DIM;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Pipeline flow control.
    assign advance   = !(res_valid && res_stall);
    assign pix_stall = !advance || mem_busy;
    assign accept    = pix_valid && !pix_stall;

    sve_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .advance      (advance),
        .req_type     (req_type),
        .pixel_value  (pixel_value),
        .image_width  (width_reg),
        .image_height (height_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item)
    );

    sve_line_mem u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (mem_busy)
    );

    sve_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res_valid  (res_valid),
        .edge_value (edge_value),
        .row_end    (row_end),
        .frame_end  (frame_end)
    );

endmodule
